// File: hdl/bsc_pkg.sv
package bsc_pkg;

    // Input command codes.
    typedef enum logic [1:0] {
        CMD_TOTAL = 2'd0,
        CMD_MAX   = 2'd1,
        CMD_ALLOC = 2'd2,
        CMD_RUN   = 2'd3
    } t_cmd;

    // Configuration register indexes.
    localparam logic CFG_NUM_PROCS = 1'b0;
    localparam logic CFG_NUM_RES   = 1'b1;

    // Width of the configuration registers.
    localparam int CFG_WIDTH = 5;

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SUB_RD,
        ST_SUB_EV,
        ST_SCAN,
        ST_CHK_RD,
        ST_CHK_EV,
        ST_ADD_RD,
        ST_ADD_EV,
        ST_EMIT,
        ST_VERDICT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic init;
        logic sub_en;
        logic add_en;
        logic r_clr;
        logic r_inc;
        logic p_clr;
        logic p_inc;
        logic emit;
        logic verdict;
    } t_ctrl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic np_zero;
        logic nr_zero;
        logic r_last;
        logic p_last;
        logic cur_done;
        logic lt;
        logic count_last;
    } t_dp_stat;

endpackage

// File: hdl/bsc_dp.sv
module bsc_dp import bsc_pkg::*; #(
    parameter int MAX_PROCS   = 16,
    parameter int MAX_RES     = 16,
    parameter int VALUE_WIDTH = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    input  logic [3:0]           i_proc_index,
    input  logic [3:0]           i_res_index,
    input  logic [15:0]          i_value,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_index,
    input  logic [CFG_WIDTH-1:0] i_cfg_data,
    input  t_ctrl_cmd            i_ctl,
    output t_dp_stat             o_stat,
    output logic                 o_valid,
    output logic [3:0]           o_proc_id,
    output logic                 o_is_verdict,
    output logic                 o_safe,
    output logic                 o_last
);

    localparam int PIW   = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int RIW   = (MAX_RES > 1) ? $clog2(MAX_RES) : 1;
    localparam int PCW   = $clog2(MAX_PROCS + 1);
    localparam int RCW   = $clog2(MAX_RES + 1);
    localparam int AW    = PIW + RIW;
    localparam int DEPTH = 1 << AW;
    localparam int WW    = VALUE_WIDTH + PIW + 2;

    logic [CFG_WIDTH-1:0]   r_num_procs;
    logic [CFG_WIDTH-1:0]   r_num_res;
    logic [PCW-1:0]         w_np;
    logic [RCW-1:0]         w_nr;
    logic [VALUE_WIDTH-1:0] w_val;
    logic                   w_idx_ok;
    logic                   w_res_ok;
    logic [AW-1:0]          w_addr_ld;
    logic [AW-1:0]          w_addr_rd;

    logic [VALUE_WIDTH-1:0] mem_max   [DEPTH];
    logic [VALUE_WIDTH-1:0] mem_alloc [DEPTH];
    logic [VALUE_WIDTH-1:0] r_max_q;
    logic [VALUE_WIDTH-1:0] r_alloc_q;
    logic [VALUE_WIDTH-1:0] r_total [MAX_RES];

    logic signed [WW-1:0]          r_work [MAX_RES];
    logic signed [VALUE_WIDTH:0]   w_need;
    logic signed [WW-1:0]          w_alloc_ext;

    logic [PIW-1:0]       r_p;
    logic [RIW-1:0]       r_r;
    logic [MAX_PROCS-1:0] r_done;
    logic [PCW-1:0]       r_count;

    logic       r_valid;
    logic [3:0] r_pid;
    logic       r_verd;
    logic       r_safe;
    logic       r_last;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_procs <= CFG_WIDTH'(16);
            r_num_res   <= CFG_WIDTH'(16);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_NUM_PROCS: r_num_procs <= i_cfg_data;
                CFG_NUM_RES:   r_num_res   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Counts in use, limited to the storage size.
    always_comb begin
        if (32'(r_num_procs) > 32'(MAX_PROCS)) begin
            w_np = PCW'(MAX_PROCS);
        end else begin
            w_np = PCW'(r_num_procs);
        end
        if (32'(r_num_res) > 32'(MAX_RES)) begin
            w_nr = RCW'(MAX_RES);
        end else begin
            w_nr = RCW'(r_num_res);
        end
    end

    // Load decode.
    assign w_val     = VALUE_WIDTH'(i_value);
    assign w_res_ok  = 32'(i_res_index) < 32'(MAX_RES);
    assign w_idx_ok  = w_res_ok && (32'(i_proc_index) < 32'(MAX_PROCS));
    assign w_addr_ld = {PIW'(i_proc_index), RIW'(i_res_index)};
    assign w_addr_rd = {r_p, r_r};

    // Maximum and allocation matrices with registered reads.
    always_ff @(posedge i_clk) begin
        if (i_ctl.load && w_idx_ok && (i_cmd == CMD_MAX)) begin
            mem_max[w_addr_ld] <= w_val;
        end
        r_max_q <= mem_max[w_addr_rd];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load && w_idx_ok && (i_cmd == CMD_ALLOC)) begin
            mem_alloc[w_addr_ld] <= w_val;
        end
        r_alloc_q <= mem_alloc[w_addr_rd];
    end

    // Total vector.
    always_ff @(posedge i_clk) begin
        if (i_ctl.load && w_res_ok && (i_cmd == CMD_TOTAL)) begin
            r_total[RIW'(i_res_index)] <= w_val;
        end
    end

    assign w_alloc_ext = $signed({{(WW - VALUE_WIDTH){1'b0}}, r_alloc_q});
    assign w_need      = $signed({1'b0, r_max_q}) - $signed({1'b0, r_alloc_q});

    // Work vector: loaded from totals, then reduced and grown by allocations.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < MAX_RES; r++) begin
                r_work[r] <= '0;
            end
        end else if (i_ctl.init) begin
            for (int r = 0; r < MAX_RES; r++) begin
                if (r < 32'(w_nr)) begin
                    r_work[r] <= $signed({{(WW - VALUE_WIDTH){1'b0}}, r_total[r]});
                end else begin
                    r_work[r] <= '0;
                end
            end
        end else if (i_ctl.sub_en) begin
            r_work[r_r] <= r_work[r_r] - w_alloc_ext;
        end else if (i_ctl.add_en) begin
            r_work[r_r] <= r_work[r_r] + w_alloc_ext;
        end
    end

    // Process and resource counters, finished flags and completion count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p     <= '0;
            r_r     <= '0;
            r_done  <= '0;
            r_count <= '0;
        end else begin
            if (i_ctl.init || i_ctl.p_clr) begin
                r_p <= '0;
            end else if (i_ctl.p_inc) begin
                r_p <= r_p + PIW'(1);
            end
            if (i_ctl.init || i_ctl.r_clr) begin
                r_r <= '0;
            end else if (i_ctl.r_inc) begin
                r_r <= r_r + RIW'(1);
            end
            if (i_ctl.init) begin
                r_done  <= '0;
                r_count <= '0;
            end else if (i_ctl.emit) begin
                r_done[r_p] <= 1'b1;
                r_count     <= r_count + PCW'(1);
            end
        end
    end

    // Status to the controller.
    always_comb begin
        o_stat.np_zero    = (w_np == '0);
        o_stat.nr_zero    = (w_nr == '0);
        o_stat.r_last     = ((RCW'(r_r) + RCW'(1)) == w_nr);
        o_stat.p_last     = ((PCW'(r_p) + PCW'(1)) == w_np);
        o_stat.cur_done   = r_done[r_p];
        o_stat.lt         = r_work[r_r] < WW'(w_need);
        o_stat.count_last = ((r_count + PCW'(1)) == w_np);
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_ctl.emit || i_ctl.verdict;
        end
        r_pid  <= i_ctl.emit ? 4'(r_p) : 4'd0;
        r_verd <= i_ctl.verdict;
        r_safe <= i_ctl.verdict && (r_count == w_np);
        r_last <= i_ctl.verdict;
    end

    assign o_valid      = r_valid;
    assign o_proc_id    = r_pid;
    assign o_is_verdict = r_verd;
    assign o_safe       = r_safe;
    assign o_last       = r_last;

endmodule

// File: hdl/bsc_ctrl.sv
module bsc_ctrl import bsc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    input  t_cmd      i_cmd,
    input  t_dp_stat  i_stat,
    output t_ctrl_cmd o_ctl,
    output logic      busy
);

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        busy    = 1'b1;
        case (r_state)
            ST_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    if (i_cmd == CMD_RUN) begin
                        o_ctl.init = 1'b1;
                        if (i_stat.np_zero) begin
                            n_state = ST_VERDICT;
                        end else if (i_stat.nr_zero) begin
                            n_state = ST_SCAN;
                        end else begin
                            n_state = ST_SUB_RD;
                        end
                    end else begin
                        o_ctl.load = 1'b1;
                    end
                end
            end
            ST_SUB_RD: begin
                n_state = ST_SUB_EV;
            end
            // Subtract one allocation from its work entry.
            ST_SUB_EV: begin
                o_ctl.sub_en = 1'b1;
                if (i_stat.r_last) begin
                    o_ctl.r_clr = 1'b1;
                    if (i_stat.p_last) begin
                        o_ctl.p_clr = 1'b1;
                        n_state     = ST_SCAN;
                    end else begin
                        o_ctl.p_inc = 1'b1;
                        n_state     = ST_SUB_RD;
                    end
                end else begin
                    o_ctl.r_inc = 1'b1;
                    n_state     = ST_SUB_RD;
                end
            end
            // Skip finished processes; check or, with no resources, emit an unfinished one.
            ST_SCAN: begin
                if (i_stat.cur_done) begin
                    if (i_stat.p_last) begin
                        n_state = ST_VERDICT;
                    end else begin
                        o_ctl.p_inc = 1'b1;
                    end
                end else if (i_stat.nr_zero) begin
                    n_state = ST_EMIT;
                end else begin
                    o_ctl.r_clr = 1'b1;
                    n_state     = ST_CHK_RD;
                end
            end
            ST_CHK_RD: begin
                n_state = ST_CHK_EV;
            end
            // Compare need against work for one resource.
            ST_CHK_EV: begin
                if (i_stat.lt) begin
                    o_ctl.r_clr = 1'b1;
                    if (i_stat.p_last) begin
                        n_state = ST_VERDICT;
                    end else begin
                        o_ctl.p_inc = 1'b1;
                        n_state     = ST_SCAN;
                    end
                end else if (i_stat.r_last) begin
                    o_ctl.r_clr = 1'b1;
                    n_state     = ST_ADD_RD;
                end else begin
                    o_ctl.r_inc = 1'b1;
                    n_state     = ST_CHK_RD;
                end
            end
            ST_ADD_RD: begin
                n_state = ST_ADD_EV;
            end
            // Release the allocation of the completing process.
            ST_ADD_EV: begin
                o_ctl.add_en = 1'b1;
                if (i_stat.r_last) begin
                    o_ctl.r_clr = 1'b1;
                    n_state     = ST_EMIT;
                end else begin
                    o_ctl.r_inc = 1'b1;
                    n_state     = ST_ADD_RD;
                end
            end
            ST_EMIT: begin
                o_ctl.emit = 1'b1;
                if (i_stat.count_last) begin
                    n_state = ST_VERDICT;
                end else begin
                    o_ctl.p_clr = 1'b1;
                    n_state     = ST_SCAN;
                end
            end
            ST_VERDICT: begin
                o_ctl.verdict = 1'b1;
                n_state       = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// File: hdl/bankers_safety_check.sv
// Banker's safety checker. Load commands (total, max, allocated) are each
// taken in the idle state and produce no result. A run seeds the work vector
// from the totals, subtracts all allocations (P processes, R resources in
// use), then for each completion scans the processes, checks need against
// work for every resource of each candidate, releases the allocation of the
// process that completes and emits it, and closes with the verdict. Each
// matrix memory has a single registered read port, so every entry pair is
// read in a read state before it is evaluated. busy is high for the whole run.
// Each completed process and the closing verdict appear on o_valid for one
// cycle; the receiver cannot stall them.
module bankers_safety_check import bsc_pkg::*; #(
    parameter int MAX_PROCS   = 16,
    parameter int MAX_RES     = 16,
    parameter int VALUE_WIDTH = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [1:0]           i_cmd,
    input  logic [3:0]           i_proc_index,
    input  logic [3:0]           i_res_index,
    input  logic [15:0]          i_value,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic                 i_cfg_index,
    input  logic [CFG_WIDTH-1:0] i_cfg_data,
    output logic                 o_valid,
    output logic [3:0]           o_proc_id,
    output logic                 o_is_verdict,
    output logic                 o_safe,
    output logic                 o_last
);

    t_ctrl_cmd w_ctl;
    t_dp_stat  w_stat;
    t_cmd      w_cmd;

    assign w_cmd       = t_cmd'(i_cmd);
    assign o_cfg_ready = 1'b1;

    bsc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_cmd   (w_cmd),
        .i_stat  (w_stat),
        .o_ctl   (w_ctl),
        .busy    (busy)
    );

    bsc_dp #(
        .MAX_PROCS   (MAX_PROCS),
        .MAX_RES     (MAX_RES),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_proc_index (i_proc_index),
        .i_res_index  (i_res_index),
        .i_value      (i_value),
        .i_cfg_we     (i_cfg_valid && o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_ctl        (w_ctl),
        .o_stat       (w_stat),
        .o_valid      (o_valid),
        .o_proc_id    (o_proc_id),
        .o_is_verdict (o_is_verdict),
        .o_safe       (o_safe),
        .o_last       (o_last)
    );

    // A run request makes the block busy in the next cycle.
    a_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (w_cmd == CMD_RUN)) |=> busy)
        else $error("run request did not start the checker");

    // Completions are only reported while the run is still going.
    a_emit_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_is_verdict) |-> busy)
        else $error("completion reported outside a run");

    // The verdict closes the run.
    a_verdict_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_is_verdict) |-> (!busy && o_last))
        else $error("verdict did not end the run");

    // A completion carries neither the safe nor the last mark.
    a_emit_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_is_verdict) |-> (!o_safe && !o_last))
        else $error("completion carries verdict flags");

endmodule
